### rtl/lpfe_pkg.sv
// ----------------------------------------------------------------------------
// lpfe_pkg: shared types and constants of the length-prefixed field extractor
// Holds the parse phase and number scan encodings, default sizes and the
// character codes that the header reader tests for.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfe_pkg;

	// default sizes
	localparam int HEADER_CHARS = 4;
	localparam int MAX_FIELDS   = 256;

	// register width
	localparam int INDEX_W = 8;
	localparam int BYTE_W  = 8;

	// character codes
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// parse phase of the stream
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_SEP    = 2'd2
	} phase_t;

	// progress of the decimal reader within one header
	typedef enum logic [1:0] {
		SC_SPACE  = 2'd0,
		SC_DIGITS = 2'd1,
		SC_STOP   = 2'd2
	} scan_t;

endpackage

`default_nettype wire

### rtl/length_prefixed_field_extract.sv
// Latency: a result item is valid in the cycle after its input item is accepted.
// Throughput: one input item per cycle; the output register is refilled while
// its item is taken, so in_ready drops only while a result item stalls.
// Each byte passes one short update of the parser counters and the scan state.
// Reset (arst_n low) clears the parser state, field_index and the output
// register; block_start clears the parser state but keeps field_index.
// ----------------------------------------------------------------------------
// length_prefixed_field_extract: body extractor for length-prefixed fields
// Parses a stream of decimal-length-prefixed fields and passes on the body
// bytes of the field at the configured position, or one not-found item.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_field_extract #(
	parameter int HEADER_CHARS = lpfe_pkg::HEADER_CHARS,
	parameter int MAX_FIELDS   = lpfe_pkg::MAX_FIELDS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [lpfe_pkg::INDEX_W-1:0] cfg_data,
	// input item channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lpfe_pkg::BYTE_W-1:0]  in_byte,
	input  wire logic                         block_start,
	// result item channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [lpfe_pkg::BYTE_W-1:0]       out_byte,
	output logic                              last,
	output logic                              not_found
);

	localparam int LEN_W = $clog2(10 ** HEADER_CHARS);
	localparam int HP_W  = (HEADER_CHARS > 1) ? $clog2(HEADER_CHARS) : 1;
	localparam int FC_W  = $clog2(MAX_FIELDS);
	localparam int CMP_W = (FC_W > lpfe_pkg::INDEX_W) ? FC_W : lpfe_pkg::INDEX_W;
	localparam logic [HP_W-1:0]  HP_LAST = HP_W'(HEADER_CHARS - 1);
	localparam logic [FC_W-1:0]  FC_MAX  = FC_W'(MAX_FIELDS - 1);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	// configuration register
	logic [lpfe_pkg::INDEX_W-1:0] field_index_q;

	// parser state
	lpfe_pkg::phase_t  phase_q, phase_d;
	lpfe_pkg::scan_t   scan_q, scan_d;
	logic [HP_W-1:0]   hpos_q, hpos_d;
	logic [LEN_W-1:0]  acc_q, acc_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic [FC_W-1:0]   fcnt_q, fcnt_d;
	logic              neg_q, neg_d;
	logic              sel_q, sel_d;
	logic              fin_q, fin_d;

	// state as seen by the current byte, after a block start clears it
	lpfe_pkg::phase_t  phase_e;
	lpfe_pkg::scan_t   scan_e;
	logic [HP_W-1:0]   hpos_e;
	logic [LEN_W-1:0]  acc_e;
	logic [LEN_W-1:0]  rem_e;
	logic [FC_W-1:0]   fcnt_e;
	logic              neg_e;
	logic              sel_e;
	logic              fin_e;

	// header character decode
	logic              is_ws;
	logic              is_sign;
	logic              is_digit;
	logic [LEN_W-1:0]  acc_x10;
	logic              hdr_done;
	logic              hdr_bad;

	// result of the current byte
	logic                        res_valid;
	logic [lpfe_pkg::BYTE_W-1:0] res_byte;
	logic                        res_last;
	logic                        res_nf;

	// output register
	logic                        out_valid_q;
	logic [lpfe_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;
	logic                        out_nf_q;

	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	// hold the configured field position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			field_index_q <= cfg_data;
		end
	end

	// apply block start ahead of the byte
	always_comb begin
		if (block_start) begin
			phase_e = lpfe_pkg::PH_HEADER;
			scan_e  = lpfe_pkg::SC_SPACE;
			hpos_e  = '0;
			acc_e   = '0;
			rem_e   = '0;
			fcnt_e  = '0;
			neg_e   = 1'b0;
			sel_e   = 1'b0;
			fin_e   = 1'b0;
		end else begin
			phase_e = phase_q;
			scan_e  = scan_q;
			hpos_e  = hpos_q;
			acc_e   = acc_q;
			rem_e   = rem_q;
			fcnt_e  = fcnt_q;
			neg_e   = neg_q;
			sel_e   = sel_q;
			fin_e   = fin_q;
		end
	end

	// classify the byte as a header character
	assign is_ws    = in_byte inside {lpfe_pkg::CH_SPACE, [lpfe_pkg::CH_TAB:lpfe_pkg::CH_CR]};
	assign is_sign  = (in_byte == lpfe_pkg::CH_PLUS) || (in_byte == lpfe_pkg::CH_MINUS);
	assign is_digit = in_byte inside {[lpfe_pkg::CH_ZERO:lpfe_pkg::CH_NINE]};
	assign acc_x10  = (acc_e << 3) + (acc_e << 1) + LEN_W'(in_byte[3:0]);
	assign hdr_done = (hpos_e == HP_LAST);

	// next parser state
	always_comb begin
		phase_d = phase_e;
		scan_d  = scan_e;
		hpos_d  = hpos_e;
		acc_d   = acc_e;
		rem_d   = rem_e;
		fcnt_d  = fcnt_e;
		neg_d   = neg_e;
		sel_d   = sel_e;
		fin_d   = fin_e;
		hdr_bad = 1'b0;
		if (!fin_e) begin
			case (phase_e)
				lpfe_pkg::PH_HEADER: begin
					// read one header character
					case (scan_e)
						lpfe_pkg::SC_SPACE: begin
							if (is_sign) begin
								neg_d  = (in_byte == lpfe_pkg::CH_MINUS);
								scan_d = lpfe_pkg::SC_DIGITS;
							end else if (!is_ws) begin
								if (is_digit) begin
									acc_d  = acc_x10;
									scan_d = lpfe_pkg::SC_DIGITS;
								end else begin
									scan_d = lpfe_pkg::SC_STOP;
								end
							end
						end
						lpfe_pkg::SC_DIGITS: begin
							if (is_digit) begin
								acc_d = acc_x10;
							end else begin
								scan_d = lpfe_pkg::SC_STOP;
							end
						end
						default: begin
						end
					endcase
					// close the header on its last character
					if (hdr_done) begin
						hdr_bad = neg_d || (acc_d == '0);
						if (hdr_bad) begin
							fin_d = 1'b1;
						end else begin
							sel_d   = (CMP_W'(fcnt_e) == CMP_W'(field_index_q));
							rem_d   = acc_d;
							phase_d = lpfe_pkg::PH_BODY;
							hpos_d  = '0;
							acc_d   = '0;
							scan_d  = lpfe_pkg::SC_SPACE;
							neg_d   = 1'b0;
						end
					end else begin
						hpos_d = hpos_e + HP_W'(1);
					end
				end
				lpfe_pkg::PH_BODY: begin
					// count down the body
					rem_d = rem_e - LEN_ONE;
					if (rem_e == LEN_ONE) begin
						if (sel_e) begin
							fin_d = 1'b1;
						end else begin
							phase_d = lpfe_pkg::PH_SEP;
						end
					end
				end
				default: begin
					// separator of a skipped field
					phase_d = lpfe_pkg::PH_HEADER;
					if (fcnt_e != FC_MAX) begin
						fcnt_d = fcnt_e + FC_W'(1);
					end
				end
			endcase
		end
	end

	// result of the byte
	always_comb begin
		res_valid = 1'b0;
		res_byte  = in_byte;
		res_last  = (rem_e == LEN_ONE);
		res_nf    = 1'b0;
		if (!fin_e) begin
			case (phase_e)
				lpfe_pkg::PH_HEADER: begin
					if (hdr_done && hdr_bad) begin
						res_valid = 1'b1;
						res_byte  = '0;
						res_last  = 1'b0;
						res_nf    = 1'b1;
					end
				end
				lpfe_pkg::PH_BODY: begin
					res_valid = sel_e;
				end
				default: begin
				end
			endcase
		end
	end

	// advance the parser on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpfe_pkg::PH_HEADER;
			scan_q  <= lpfe_pkg::SC_SPACE;
			hpos_q  <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			fcnt_q  <= '0;
			neg_q   <= 1'b0;
			sel_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			scan_q  <= scan_d;
			hpos_q  <= hpos_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			fcnt_q  <= fcnt_d;
			neg_q   <= neg_d;
			sel_q   <= sel_d;
			fin_q   <= fin_d;
		end
	end

	// output register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_byte_q <= '0;
			out_last_q <= 1'b0;
			out_nf_q   <= 1'b0;
		end else if (in_fire) begin
			out_byte_q <= res_byte;
			out_last_q <= res_last;
			out_nf_q   <= res_nf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;
	assign not_found = out_nf_q;

endmodule

`default_nettype wire

### rtl/lpfe_checker.sv
// ----------------------------------------------------------------------------
// lpfe_checker: port-level checks of the length-prefixed field extractor
// Watches the item channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfe_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        block_start,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [lpfe_pkg::BYTE_W-1:0] out_byte,
	input wire logic                        last,
	input wire logic                        not_found
);

	// a not-found item carries no byte and no last mark
	a_nf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_found |-> (out_byte == '0) && !last)
		else $error("not-found item carries byte or last");

	// nothing follows the end of a search without a new block
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (last || not_found)
		&& !(in_valid && in_ready && block_start) |=> !out_valid)
		else $error("item after end of search");

	// an empty output register never stalls the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
		&& $stable(last) && $stable(not_found))
		else $error("stalled result item changed");

endmodule

bind length_prefixed_field_extract lpfe_checker u_lpfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.block_start (block_start),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.last        (last),
	.not_found   (not_found)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for length_prefixed_field_extract
// Drives byte streams of length-prefixed fields through the valid/ready input
// channel and tracks the parser state alongside the block. Each body byte or
// not-found item that leaves the block is compared with the next expected one.
// Directed streams come first, then a receiver hold-off, then random blocks
// under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;

	localparam int STALL_LIMIT = 2000;

	// one result item of the block
	typedef struct packed {
		logic [lpfe_pkg::BYTE_W-1:0] data;
		logic                        is_last;
		logic                        miss;
	} field_byte_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_valid   = 1'b0;
	logic                          cfg_ready;
	logic [lpfe_pkg::INDEX_W-1:0]  cfg_data    = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic [lpfe_pkg::BYTE_W-1:0]   in_byte     = '0;
	logic                          block_start = 1'b0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [lpfe_pkg::BYTE_W-1:0]   out_byte;
	logic                          last;
	logic                          not_found;

	// bench parser state, tracked per accepted item
	lpfe_pkg::phase_t              parse_phase;
	lpfe_pkg::scan_t               scan_state;
	logic [2:0]                    hdr_count;
	logic [13:0]                   len_sum;
	logic                          len_neg;
	logic [13:0]                   body_left;
	logic [7:0]                    field_no;
	logic                          want_field;
	logic                          search_done;
	logic [lpfe_pkg::INDEX_W-1:0]  field_index_cfg;

	field_byte_t                   expected_bytes[$];
	logic [lpfe_pkg::BYTE_W-1:0]   stim_bytes[$];

	int                            error_count   = 0;
	int                            items_sent    = 0;
	int                            send_idle_pct = 0;
	int                            stall_pct     = 0;
	int                            hold_left     = 0;
	int                            quiet_cycles  = 0;

	length_prefixed_field_extract dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last),
		.not_found   (not_found)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser prediction
	// ------------------------------------------------------------------

	task automatic clear_parser();
		parse_phase = lpfe_pkg::PH_HEADER;
		scan_state  = lpfe_pkg::SC_SPACE;
		hdr_count   = '0;
		len_sum     = '0;
		len_neg     = 1'b0;
		body_left   = '0;
		field_no    = '0;
		want_field  = 1'b0;
		search_done = 1'b0;
	endtask

	// Advance the parser by one accepted byte and queue any result it causes.
	task automatic parse_byte(input logic [lpfe_pkg::BYTE_W-1:0] b, input logic start);
		logic take_digit;
		if (start)
			clear_parser();
		take_digit = 1'b0;
		if (!search_done) begin
			case (parse_phase)
			lpfe_pkg::PH_HEADER: begin
				// skip whitespace, take one sign, then add up digits
				if (scan_state == lpfe_pkg::SC_SPACE) begin
					if (b == lpfe_pkg::CH_SPACE
							|| (b >= lpfe_pkg::CH_TAB && b <= lpfe_pkg::CH_CR)) begin
						take_digit = 1'b0;
					end else if (b == lpfe_pkg::CH_PLUS || b == lpfe_pkg::CH_MINUS) begin
						if (b == lpfe_pkg::CH_MINUS)
							len_neg = 1'b1;
						scan_state = lpfe_pkg::SC_DIGITS;
					end else begin
						scan_state = lpfe_pkg::SC_DIGITS;
						take_digit = 1'b1;
					end
				end else if (scan_state == lpfe_pkg::SC_DIGITS) begin
					take_digit = 1'b1;
				end
				if (take_digit) begin
					if (b >= lpfe_pkg::CH_ZERO && b <= lpfe_pkg::CH_NINE)
						len_sum = len_sum * 14'd10 + 14'(b - lpfe_pkg::CH_ZERO);
					else
						scan_state = lpfe_pkg::SC_STOP;
				end
				hdr_count = hdr_count + 3'd1;
				if (hdr_count == lpfe_pkg::HEADER_CHARS) begin
					if (len_neg || len_sum == 0) begin
						// zero or negative length ends the search
						search_done = 1'b1;
						expected_bytes.push_back(
							field_byte_t'{data: '0, is_last: 1'b0, miss: 1'b1});
					end else begin
						want_field  = (field_no == field_index_cfg);
						body_left   = len_sum;
						parse_phase = lpfe_pkg::PH_BODY;
						hdr_count   = '0;
						len_sum     = '0;
						scan_state  = lpfe_pkg::SC_SPACE;
						len_neg     = 1'b0;
					end
				end
			end
			lpfe_pkg::PH_BODY: begin
				body_left = body_left - 14'd1;
				if (want_field) begin
					expected_bytes.push_back(
						field_byte_t'{data: b, is_last: (body_left == 0), miss: 1'b0});
					if (body_left == 0)
						search_done = 1'b1;
				end else if (body_left == 0) begin
					parse_phase = lpfe_pkg::PH_SEP;
				end
			end
			default: begin
				// separator of a skipped field
				parse_phase = lpfe_pkg::PH_HEADER;
				if (field_no != 8'(lpfe_pkg::MAX_FIELDS - 1))
					field_no = field_no + 8'd1;
			end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : check_results
		field_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("result item with none expected", out_byte, 0);
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
				if (last !== want.is_last)
					report_mismatch("last", last, want.is_last);
				if (not_found !== want.miss)
					report_mismatch("not_found", not_found, want.miss);
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one item, hold it until accepted, then idle at random.
	task automatic send_item(input logic [lpfe_pkg::BYTE_W-1:0] b, input logic start);
		in_byte     = b;
		block_start = start;
		in_valid    = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		parse_byte(b, start);
		items_sent++;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// send the staged bytes, marking the first as a block start if asked
	task automatic send_stim(input logic with_start);
		foreach (stim_bytes[i])
			send_item(stim_bytes[i], with_start && i == 0);
		stim_bytes = {};
	endtask

	// Drop valid and wait until every expected item is in, plus the latency.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_field_index(input logic [lpfe_pkg::INDEX_W-1:0] value);
		wait_idle();
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		field_index_cfg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [lpfe_pkg::BYTE_W-1:0] pick_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? lpfe_pkg::CH_SPACE : lpfe_pkg::CH_TAB + 8'(r);
	endfunction

	function automatic logic [lpfe_pkg::INDEX_W-1:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return '1;
		return lpfe_pkg::INDEX_W'($urandom_range(0, 5));
	endfunction

	function automatic logic [lpfe_pkg::BYTE_W-1:0] rand_byte();
		return lpfe_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	// Stage a header for a length below 100: right aligned after whitespace or
	// zeros, or left aligned with a non-digit tail.
	task automatic add_header(input int unsigned len,
			input logic [lpfe_pkg::BYTE_W-1:0] sign);
		logic [lpfe_pkg::BYTE_W-1:0] chars[$];
		logic [lpfe_pkg::BYTE_W-1:0] pad;
		int                          mode;
		chars = {};
		if (sign != 8'h00)
			chars.push_back(sign);
		if (len >= 10)
			chars.push_back(lpfe_pkg::CH_ZERO + 8'(len / 10));
		chars.push_back(lpfe_pkg::CH_ZERO + 8'(len % 10));
		mode = $urandom_range(0, 2);
		while (chars.size() < lpfe_pkg::HEADER_CHARS) begin
			case (mode)
			0: chars.push_front(pick_space());
			1: chars.push_front((sign == 8'h00) ? lpfe_pkg::CH_ZERO : pick_space());
			default: begin
				pad = rand_byte();
				if (pad >= lpfe_pkg::CH_ZERO && pad <= lpfe_pkg::CH_NINE)
					pad = lpfe_pkg::CH_SPACE;
				chars.push_back(pad);
			end
			endcase
		end
		foreach (chars[i])
			stim_bytes.push_back(chars[i]);
	endtask

	// One block: mostly well-formed fields, some ending the search, some
	// garbage, sometimes cut short; now and then pure noise instead.
	task automatic send_random_block();
		int nf;
		int kind;
		int len;
		int cut;
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(4, 12))
				send_item(rand_byte(), $urandom_range(0, 3) == 0);
		end else begin
			nf = $urandom_range(1, 6);
			repeat (nf) begin
				kind = $urandom_range(0, 99);
				if (kind < 6) begin
					add_header(0, ($urandom_range(0, 2) == 0) ? lpfe_pkg::CH_PLUS : 8'h00);
				end else if (kind < 11) begin
					add_header($urandom_range(0, 60), lpfe_pkg::CH_MINUS);
				end else if (kind < 15) begin
					repeat (lpfe_pkg::HEADER_CHARS)
						stim_bytes.push_back(rand_byte());
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
						: $urandom_range(1, 8);
					add_header(len, ($urandom_range(0, 3) == 0) ? lpfe_pkg::CH_PLUS : 8'h00);
					repeat (len)
						stim_bytes.push_back(rand_byte());
					stim_bytes.push_back(rand_byte());
				end
			end
			// trailing bytes after the fields
			repeat ($urandom_range(0, 3))
				stim_bytes.push_back(rand_byte());
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, stim_bytes.size());
				while (stim_bytes.size() > cut)
					void'(stim_bytes.pop_back());
			end
			send_stim(1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		// no block start after reset; sign and tail stop; 0x00 and 0xFF body
		stim_bytes = {lpfe_pkg::CH_SPACE, lpfe_pkg::CH_PLUS, lpfe_pkg::CH_ZERO + 8'd2,
			8'h78, 8'h00, 8'hFF, 8'h35};
		send_stim(1'b0);
		// skip field zero behind tab and space, then a minus sign
		write_field_index(8'd1);
		stim_bytes = {lpfe_pkg::CH_TAB, lpfe_pkg::CH_SPACE, lpfe_pkg::CH_ZERO + 8'd1,
			lpfe_pkg::CH_SPACE, 8'h41, 8'h7C, lpfe_pkg::CH_MINUS, lpfe_pkg::CH_ZERO,
			lpfe_pkg::CH_ZERO, lpfe_pkg::CH_ZERO + 8'd1};
		send_stim(1'b1);
		// zero length
		stim_bytes = {lpfe_pkg::CH_ZERO, lpfe_pkg::CH_ZERO, lpfe_pkg::CH_ZERO,
			lpfe_pkg::CH_ZERO};
		send_stim(1'b1);
		// a second sign stops the number at zero
		stim_bytes = {lpfe_pkg::CH_PLUS, lpfe_pkg::CH_PLUS, lpfe_pkg::CH_ZERO + 8'd1,
			lpfe_pkg::CH_SPACE};
		send_stim(1'b1);
		wait_idle();
	endtask

	// Hold the receiver off while a long selected field streams in.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		write_field_index(8'd0);
		@(posedge clk);
		hold_left = 150;
		@(negedge clk);
		add_header(40, 8'h00);
		repeat (40)
			stim_bytes.push_back(rand_byte());
		stim_bytes.push_back(lpfe_pkg::CH_SPACE);
		send_stim(1'b1);
		wait_idle();
	endtask

	task automatic test_random(input int in_pct, input int out_pct,
			input logic [lpfe_pkg::INDEX_W-1:0] first_index, input int count);
		int stop_at;
		send_idle_pct = in_pct;
		stall_pct     = out_pct;
		write_field_index(first_index);
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 3) == 0)
				write_field_index(pick_index());
			send_random_block();
		end
		wait_idle();
	endtask

	initial begin
		clear_parser();
		field_index_cfg = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random(0, 0, 8'h00, 150);
		test_random(65, 0, 8'hFF, 150);
		test_random(0, 65, pick_index(), 150);
		test_random(15, 15, pick_index(), 150);

		wait_idle();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### length_prefixed_field_extract.f
rtl/lpfe_pkg.sv
rtl/length_prefixed_field_extract.sv
rtl/lpfe_checker.sv
sim/testbench.sv
